// ===== rtl/mpks_pkg.sv =====
// Shared types, codes and timing constants for the modem power key sequencer.
`timescale 1ns / 1ps

package mpks_pkg;

  // Operation codes carried on the input channel
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_DELAY = 3'd3,
    OP_RESET = 3'd4
  } op_t;

  // Outcome codes returned with every word
  typedef enum logic [1:0] {
    OUT_WORKING = 2'd0,
    OUT_OK      = 2'd1,
    OUT_ERROR   = 2'd2,
    OUT_TIMEOUT = 2'd3
  } outcome_t;

  typedef logic [2:0]  step_t;
  typedef logic [15:0] ms_t;

  // Shared step register, as read by the power-on sequence
  localparam step_t SS_CHECK      = 3'd0;
  localparam step_t SS_WAIT_UP    = 3'd1;
  localparam step_t SS_PRESS      = 3'd2;
  localparam step_t SS_PRESS_HOLD = 3'd3;
  localparam step_t SS_RELEASE    = 3'd4;
  localparam step_t SS_BOOT       = 3'd5;
  localparam step_t SS_SETTLE     = 3'd6;

  // Same register, as read by the power-off sequence
  localparam step_t PS_CHECK     = 3'd0;
  localparam step_t PS_WAIT_DOWN = 3'd1;
  localparam step_t PS_RECHECK   = 3'd2;
  localparam step_t PS_PRESS     = 3'd3;
  localparam step_t PS_WAIT_OFF  = 3'd4;
  localparam step_t PS_SETTLE    = 3'd5;

  // Same register, as read by the generic delay
  localparam step_t DS_LOAD = 3'd0;
  localparam step_t DS_WAIT = 3'd1;

  // Timer loads in millisecond ticks
  localparam ms_t T_CHECK_MS   = 16'd600;
  localparam ms_t T_PRESS_MS   = 16'd100;
  localparam ms_t T_RELEASE_MS = 16'd1500;
  localparam ms_t T_BOOT_MS    = 16'd2500;
  localparam ms_t T_SETTLE_MS  = 16'd1000;
  localparam ms_t T_OFF_MS     = 16'd3000;
  localparam ms_t T_RECHECK_MS = 16'd500;

  // One operation handed to the sequencer core
  typedef struct packed {
    logic       fire;
    logic [2:0] opcode;
    logic       up;
    ms_t        ticks;
  } seq_req_t;

  // Result of that operation, levels after its update
  typedef struct packed {
    outcome_t outcome;
    logic     powerkey;
    logic     netlight;
  } seq_rsp_t;

endpackage

// ===== rtl/mpks_if.sv =====
// Valid/ready channel interfaces for the sequencer's input and result words.
`timescale 1ns / 1ps

interface mpks_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic        status_line;
  logic [15:0] delay_ms;

  modport source (output valid, opcode, status_line, delay_ms, input ready);
  modport sink   (input valid, opcode, status_line, delay_ms, output ready);
endinterface

interface mpks_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic       powerkey_on;
  logic       netlight_on;

  modport source (output valid, outcome, powerkey_on, netlight_on, input ready);
  modport sink   (input valid, outcome, powerkey_on, netlight_on, output ready);
endinterface

// ===== rtl/mpks_seq.sv =====
// Sequencer core: step register, down-timer and output levels with their update logic.
`timescale 1ns / 1ps

module mpks_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  mpks_pkg::seq_req_t req,
  output mpks_pkg::seq_rsp_t rsp
);
  import mpks_pkg::*;

  step_t step_r, step_nxt;
  ms_t   timer_r, timer_nxt;
  logic  pk_r, pk_nxt;
  logic  nl_r, nl_nxt;
  outcome_t outcome;
  logic  tmo;

  assign tmo = (timer_r == '0);

  // Next state for the word in flight
  always_comb begin
    step_nxt  = step_r;
    timer_nxt = timer_r;
    pk_nxt    = pk_r;
    nl_nxt    = nl_r;
    if (req.fire) begin
      case (req.opcode)
        OP_TICK: begin
          if (!tmo) timer_nxt = timer_r - 16'd1;
        end
        OP_START: begin
          case (step_r)
            SS_CHECK: begin
              if (req.up) begin
                timer_nxt = T_CHECK_MS;
                step_nxt  = SS_WAIT_UP;
              end else begin
                step_nxt = SS_PRESS;
              end
            end
            SS_WAIT_UP: begin
              if (tmo) begin
                if (req.up) begin
                  nl_nxt   = 1'b1;
                  pk_nxt   = 1'b1;
                  step_nxt = SS_CHECK;
                end else begin
                  step_nxt = SS_PRESS;
                end
              end
            end
            SS_PRESS: begin
              nl_nxt    = 1'b1;
              pk_nxt    = 1'b1;
              timer_nxt = T_PRESS_MS;
              step_nxt  = SS_PRESS_HOLD;
            end
            SS_PRESS_HOLD: begin
              if (tmo) begin
                nl_nxt    = 1'b0;
                pk_nxt    = 1'b0;
                timer_nxt = T_RELEASE_MS;
                step_nxt  = SS_RELEASE;
              end
            end
            SS_RELEASE: begin
              if (tmo) begin
                pk_nxt    = 1'b1;
                timer_nxt = T_BOOT_MS;
                step_nxt  = SS_BOOT;
              end
            end
            SS_BOOT: begin
              if (req.up) begin
                timer_nxt = T_SETTLE_MS;
                step_nxt  = SS_SETTLE;
                nl_nxt    = 1'b1;
              end else if (tmo) begin
                step_nxt = SS_CHECK;
              end
            end
            SS_SETTLE: begin
              if (tmo) step_nxt = SS_CHECK;
            end
            default: step_nxt = SS_CHECK;
          endcase
        end
        OP_STOP: begin
          case (step_r)
            PS_CHECK: begin
              pk_nxt = 1'b1;
              if (!req.up) begin
                timer_nxt = T_OFF_MS;
                step_nxt  = PS_WAIT_DOWN;
              end else begin
                step_nxt = PS_PRESS;
              end
            end
            PS_WAIT_DOWN: begin
              if (req.up) begin
                timer_nxt = T_RECHECK_MS;
                step_nxt  = PS_RECHECK;
              end else if (tmo) begin
                nl_nxt   = 1'b0;
                step_nxt = PS_CHECK;
              end
            end
            PS_RECHECK: begin
              if (tmo) step_nxt = PS_PRESS;
            end
            PS_PRESS: begin
              timer_nxt = T_OFF_MS;
              pk_nxt    = 1'b0;
              nl_nxt    = 1'b0;
              step_nxt  = PS_WAIT_OFF;
            end
            PS_WAIT_OFF: begin
              if (!req.up && (timer_r < T_SETTLE_MS)) begin
                timer_nxt = T_SETTLE_MS;
                pk_nxt    = 1'b1;
                step_nxt  = PS_SETTLE;
              end else if (tmo) begin
                pk_nxt   = 1'b1;
                step_nxt = PS_CHECK;
              end
            end
            PS_SETTLE: begin
              if (tmo) step_nxt = PS_CHECK;
            end
            default: step_nxt = PS_CHECK;
          endcase
        end
        OP_DELAY: begin
          case (step_r)
            DS_LOAD: begin
              timer_nxt = req.ticks;
              step_nxt  = DS_WAIT;
            end
            DS_WAIT: begin
              if (tmo) step_nxt = DS_LOAD;
            end
            default: step_nxt = DS_LOAD;
          endcase
        end
        OP_RESET: step_nxt = SS_CHECK;
        default: ;
      endcase
    end
  end

  // Outcome code for the word in flight
  always_comb begin
    outcome = OUT_WORKING;
    case (req.opcode)
      OP_START: begin
        if (step_r == SS_WAIT_UP && tmo && req.up) outcome = OUT_OK;
        else if (step_r == SS_BOOT && !req.up && tmo) outcome = OUT_TIMEOUT;
        else if (step_r == SS_SETTLE && tmo) outcome = req.up ? OUT_OK : OUT_ERROR;
      end
      OP_STOP: begin
        if (step_r == PS_WAIT_DOWN && !req.up && tmo) outcome = OUT_OK;
        else if (step_r == PS_WAIT_OFF && req.up && tmo) outcome = OUT_TIMEOUT;
        else if (step_r == PS_SETTLE && tmo) outcome = req.up ? OUT_ERROR : OUT_OK;
      end
      OP_DELAY: begin
        if (step_r == DS_WAIT && tmo) outcome = OUT_OK;
      end
      default: outcome = OUT_WORKING;
    endcase
  end

  // Levels are reported after the word's update
  assign rsp.outcome  = outcome;
  assign rsp.powerkey = pk_nxt;
  assign rsp.netlight = nl_nxt;

  // Hold state between words, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      timer_r <= '0;
      pk_r    <= 1'b0;
      nl_r    <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
      pk_r    <= pk_nxt;
      nl_r    <= nl_nxt;
    end
  end

  // A finished sequence always returns the step register to its start
  a_done_clears_step: assert property (@(posedge clk) disable iff (!rst_n)
    (req.fire && rsp.outcome != OUT_WORKING) |=> step_r == '0)
    else $error("step not cleared after a finished sequence");

  a_reset_op: assert property (@(posedge clk) disable iff (!rst_n)
    (req.fire && req.opcode == OP_RESET) |=> step_r == '0)
    else $error("reset operation left the step register set");

  a_tick_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (req.fire && req.opcode == OP_TICK && !tmo) |=> timer_r == $past(timer_r) - 16'd1)
    else $error("tick did not decrement the timer");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !req.fire |=> ($stable(step_r) && $stable(timer_r) && $stable(pk_r) && $stable(nl_r)))
    else $error("state moved without a word");

endmodule

// ===== rtl/modem_power_key_sequencer.sv =====
// Top level of the modem power key sequencer: input stage, core and result register.
//
// Usage:
//   in_ch carries one operation word per handshake: opcode (tick, start step,
//   stop step, delay step, reset sequence), the modem status pin level and a
//   delay length for the delay step. out_ch returns exactly one word per input
//   word, in order: an outcome code and the power key and netlight levels as
//   they stand after that operation.
//   A word accepted into the input register is applied to the step register,
//   down-timer and levels, and its result is loaded into the result register,
//   when the input stage advances; a full, stalled result register holds it back.
//   Throughput: one word per cycle while out_ch.ready stays high; the input
//   register feeds the result register through one pass of core next-state logic.
//   Reset (synchronous, rst_n low): both pipeline stages empty, step register
//   and down-timer to zero, power key and netlight off.
//   Stall: when out_ch.ready is low the result register holds its word; the
//   input register still takes one more word, then in_ch.ready drops until
//   the result is taken.
`timescale 1ns / 1ps

module modem_power_key_sequencer (
  input logic       clk,
  input logic       rst_n,
  mpks_in_if.sink   in_ch,
  mpks_out_if.source out_ch
);
  import mpks_pkg::*;

  logic       s1_valid_r;
  logic [2:0] s1_opcode_r;
  logic       s1_up_r;
  ms_t        s1_ticks_r;
  logic       s1_go;
  logic       in_fire;

  logic       out_valid_r;
  seq_rsp_t   out_r;

  seq_req_t   req;
  seq_rsp_t   rsp;

  // Advance the input stage when the result register is free or draining
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r <= in_ch.opcode;
      s1_up_r     <= in_ch.status_line;
      s1_ticks_r  <= in_ch.delay_ms;
    end
  end

  // Apply the staged word to the sequencer state
  assign req.fire   = s1_go;
  assign req.opcode = s1_opcode_r;
  assign req.up     = s1_up_r;
  assign req.ticks  = s1_ticks_r;

  mpks_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_r <= rsp;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.outcome     = out_r.outcome;
  assign out_ch.powerkey_on = out_r.powerkey;
  assign out_ch.netlight_on = out_r.netlight;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the modem power key sequencer.
`timescale 1ns / 1ps

module testbench;
  import mpks_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1625;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PRINT_LIMIT  = 100;

  // Opcodes the block leaves unused
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  localparam seq_rsp_t IDLE_OFF = '{OUT_WORKING, 1'b0, 1'b0};
  localparam seq_rsp_t DONE_OFF = '{OUT_OK, 1'b0, 1'b0};

  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    logic [2:0] op;
    logic       up;
    ms_t        ms;
    logic       fixed;
    seq_rsp_t   rsp;
  } vector_t;

  logic clk;
  logic rst_n;

  mpks_in_if  in_ch ();
  mpks_out_if out_ch ();

  modem_power_key_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow state of the sequencer
  step_t seq_step;
  ms_t   down_ms;
  logic  key_level;
  logic  led_level;

  seq_rsp_t    pending_rsp[$];
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned burst_left;
  rx_mode_t    rx_mode;
  int unsigned rx_left;

  // Directed words: expected result typed in only where it is obvious
  vector_t directed_vec [0:24] = '{
    '{OP_TICK,    1'b0, 16'h0000, 1'b1, IDLE_OFF},
    '{OP_SPARE_A, 1'b1, 16'hFFFF, 1'b1, IDLE_OFF},
    '{OP_SPARE_B, 1'b0, 16'h5555, 1'b1, IDLE_OFF},
    '{OP_SPARE_C, 1'b1, 16'hAAAA, 1'b1, IDLE_OFF},
    '{OP_RESET,   1'b1, 16'h0000, 1'b1, IDLE_OFF},
    '{OP_DELAY,   1'b0, 16'h0000, 1'b1, IDLE_OFF},
    '{OP_DELAY,   1'b1, 16'hFFFF, 1'b1, DONE_OFF},
    '{OP_DELAY,   1'b0, 16'hFFFF, 1'b1, IDLE_OFF},
    '{OP_TICK,    1'b1, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_DELAY,   1'b0, 16'h0001, 1'b0, IDLE_OFF},
    '{OP_RESET,   1'b0, 16'hFFFF, 1'b0, IDLE_OFF},
    '{OP_START,   1'b1, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_STOP,    1'b0, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_DELAY,   1'b1, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_RESET,   1'b0, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_START,   1'b0, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_START,   1'b0, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_DELAY,   1'b0, 16'h1234, 1'b0, IDLE_OFF},
    '{OP_STOP,    1'b1, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_STOP,    1'b1, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_STOP,    1'b0, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_START,   1'b0, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_RESET,   1'b1, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_STOP,    1'b0, 16'h0000, 1'b0, IDLE_OFF},
    '{OP_DELAY,   1'b1, 16'h0005, 1'b0, IDLE_OFF}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Power-on sequence, one step
  function automatic outcome_t start_advance(logic up);
    outcome_t res;
    res = OUT_WORKING;
    case (seq_step)
      SS_CHECK: begin
        if (up) begin
          down_ms  = T_CHECK_MS;
          seq_step = SS_WAIT_UP;
        end else begin
          seq_step = SS_PRESS;
        end
      end
      SS_WAIT_UP: begin
        if (down_ms == 0) begin
          if (up) begin
            led_level = 1'b1;
            key_level = 1'b1;
            seq_step  = SS_CHECK;
            res       = OUT_OK;
          end else begin
            seq_step = SS_PRESS;
          end
        end
      end
      SS_PRESS: begin
        led_level = 1'b1;
        key_level = 1'b1;
        down_ms   = T_PRESS_MS;
        seq_step  = SS_PRESS_HOLD;
      end
      SS_PRESS_HOLD: begin
        if (down_ms == 0) begin
          led_level = 1'b0;
          key_level = 1'b0;
          down_ms   = T_RELEASE_MS;
          seq_step  = SS_RELEASE;
        end
      end
      SS_RELEASE: begin
        if (down_ms == 0) begin
          key_level = 1'b1;
          down_ms   = T_BOOT_MS;
          seq_step  = SS_BOOT;
        end
      end
      SS_BOOT: begin
        if (up) begin
          down_ms   = T_SETTLE_MS;
          seq_step  = SS_SETTLE;
          led_level = 1'b1;
        end else if (down_ms == 0) begin
          seq_step = SS_CHECK;
          res      = OUT_TIMEOUT;
        end
      end
      SS_SETTLE: begin
        if (down_ms == 0) begin
          seq_step = SS_CHECK;
          res      = up ? OUT_OK : OUT_ERROR;
        end
      end
      default: seq_step = SS_CHECK;
    endcase
    return res;
  endfunction

  // Power-off sequence, one step
  function automatic outcome_t stop_advance(logic up);
    outcome_t res;
    res = OUT_WORKING;
    case (seq_step)
      PS_CHECK: begin
        key_level = 1'b1;
        if (!up) begin
          down_ms  = T_OFF_MS;
          seq_step = PS_WAIT_DOWN;
        end else begin
          seq_step = PS_PRESS;
        end
      end
      PS_WAIT_DOWN: begin
        if (up) begin
          down_ms  = T_RECHECK_MS;
          seq_step = PS_RECHECK;
        end else if (down_ms == 0) begin
          led_level = 1'b0;
          seq_step  = PS_CHECK;
          res       = OUT_OK;
        end
      end
      PS_RECHECK: begin
        if (down_ms == 0) seq_step = PS_PRESS;
      end
      PS_PRESS: begin
        down_ms   = T_OFF_MS;
        key_level = 1'b0;
        led_level = 1'b0;
        seq_step  = PS_WAIT_OFF;
      end
      PS_WAIT_OFF: begin
        if (!up && down_ms < T_SETTLE_MS) begin
          down_ms   = T_SETTLE_MS;
          key_level = 1'b1;
          seq_step  = PS_SETTLE;
        end else if (down_ms == 0) begin
          key_level = 1'b1;
          seq_step  = PS_CHECK;
          res       = OUT_TIMEOUT;
        end
      end
      PS_SETTLE: begin
        if (down_ms == 0) begin
          seq_step = PS_CHECK;
          res      = up ? OUT_ERROR : OUT_OK;
        end
      end
      default: seq_step = PS_CHECK;
    endcase
    return res;
  endfunction

  // Apply one word to the shadow state and return the result it yields
  function automatic seq_rsp_t apply_word(logic [2:0] op, logic up, ms_t ms);
    outcome_t res;
    res = OUT_WORKING;
    case (op)
      OP_TICK: begin
        if (down_ms != 0) down_ms = down_ms - 16'd1;
      end
      OP_START: res = start_advance(up);
      OP_STOP:  res = stop_advance(up);
      OP_DELAY: begin
        if (seq_step == DS_LOAD) begin
          down_ms  = ms;
          seq_step = DS_WAIT;
        end else if (seq_step == DS_WAIT) begin
          if (down_ms == 0) begin
            seq_step = DS_LOAD;
            res      = OUT_OK;
          end
        end else begin
          seq_step = DS_LOAD;
        end
      end
      OP_RESET: seq_step = SS_CHECK;
      default: ;
    endcase
    return '{res, key_level, led_level};
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    if (fail_count < PRINT_LIMIT)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  // Send one word in bursts with random gaps; return the predicted result
  task automatic send_word(input logic [2:0] op, input logic up, input ms_t ms,
                           output seq_rsp_t predicted);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.status_line <= up;
    in_ch.delay_ms    <= ms;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    predicted = apply_word(op, up, ms);
  endtask

  task automatic send_checked(logic [2:0] op, logic up, ms_t ms, bit counted);
    seq_rsp_t predicted;
    send_word(op, up, ms, predicted);
    pending_rsp.push_back(predicted);
    if (counted) words_sent++;
  endtask

  task automatic run_ticks(int unsigned count, bit counted);
    repeat (count) send_checked(OP_TICK, 1'($urandom_range(0, 1)), ms_t'($urandom), counted);
  endtask

  // Receiver: ready pattern that switches mode after runs of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        RX_FLOW:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default:   out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  // Compare each result word with the oldest expectation
  always @(negedge clk) begin
    seq_rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        flag_mismatch("unexpected word, outcome", out_ch.outcome, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_ch.outcome !== want.outcome)
          flag_mismatch("outcome", out_ch.outcome, want.outcome);
        if (out_ch.powerkey_on !== want.powerkey)
          flag_mismatch("powerkey_on", out_ch.powerkey_on, want.powerkey);
        if (out_ch.netlight_on !== want.netlight)
          flag_mismatch("netlight_on", out_ch.netlight_on, want.netlight);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("** modem_power_key_sequencer: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    seq_rsp_t    predicted;
    logic [2:0]  kind;
    logic [2:0]  op;
    logic        slow;
    ms_t         ms;
    int unsigned floor_ms;
    int unsigned pick;
    int unsigned n;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_TICK;
    in_ch.status_line = 1'b0;
    in_ch.delay_ms    = '0;
    fail_count        = 0;
    words_sent        = 0;
    burst_left        = 0;
    seq_step          = SS_CHECK;
    down_ms           = '0;
    key_level         = 1'b0;
    led_level         = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_vec[i]) begin
      send_word(directed_vec[i].op, directed_vec[i].up, directed_vec[i].ms, predicted);
      pending_rsp.push_back(directed_vec[i].fixed ? directed_vec[i].rsp : predicted);
    end

    // Random sequences: mostly one step kind, some noise, some run to the end
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? OP_START : (pick < 7) ? OP_STOP : OP_DELAY;
      slow = ($urandom_range(0, 3) == 0);
      n = 0;
      do begin
        op = kind;
        if ($urandom_range(0, 7) == 0) op = 3'($urandom_range(0, 7));
        else if (kind == OP_START && seq_step == SS_SETTLE && $urandom_range(0, 2) == 0)
          op = OP_STOP;
        ms = ($urandom_range(0, 3) == 0) ? ms_t'($urandom) : ms_t'($urandom_range(0, 24));
        send_checked(op, 1'($urandom_range(0, 1)), ms, op < OP_SPARE_A);
        // Let time pass: drain the timer in slow sequences while the word budget allows,
        // short bursts otherwise
        if (down_ms != 0) begin
          if (slow && down_ms <= T_OFF_MS) begin
            floor_ms = ($urandom_range(0, 3) == 0)
                       ? $urandom_range(T_SETTLE_MS - 3, T_SETTLE_MS + 1)
                       : $urandom_range(0, 1);
            if (down_ms > floor_ms && words_sent + down_ms - floor_ms <= RANDOM_WORDS)
              run_ticks(down_ms - floor_ms, 1'b1);
          end else begin
            run_ticks($urandom_range(0, 10), 1'b1);
          end
        end
        n++;
      end while (seq_step != SS_CHECK && n < 16);
      if ($urandom_range(0, 5) == 0)
        send_checked(OP_RESET, 1'($urandom_range(0, 1)), ms_t'($urandom), 1'b1);
    end
    in_ch.valid <= 1'b0;

    // Wait for every result, then let the pipeline drain
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** modem_power_key_sequencer: PASSED **");
    end else begin
      $display("** modem_power_key_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mpks_pkg.sv
rtl/mpks_if.sv
rtl/mpks_seq.sv
rtl/modem_power_key_sequencer.sv
bench/testbench.sv
